[hw/rtl/gbcs_pkg.sv]
// shared types and constants of the grid-bucketed corner selector
`timescale 1ns / 1ps

package gbcs_pkg;

  localparam int COORD_W = 14;
  localparam int IN_COORD_W = 11;
  localparam int SCORE_W = 24;
  localparam int LVL_W = 2;
  localparam int CMD_W = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;
  localparam int DIV_STEPS = 14;

  // command codes
  localparam logic [CMD_W-1:0] CMD_CAND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MARK = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_ACROSS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_DOWN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SCORE = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [IN_COORD_W-1:0] corner_x;
    logic [IN_COORD_W-1:0] corner_y;
    logic [LVL_W-1:0] level;
    logic [SCORE_W-1:0] corner_score;
  } in_item_t;

  typedef struct packed {
    logic found;
    logic [COORD_W-1:0] feature_x;
    logic [COORD_W-1:0] feature_y;
    logic [LVL_W-1:0] feature_level;
    logic [SCORE_W-1:0] feature_score;
    logic last;
  } out_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [LVL_W-1:0] lvl;
    logic [SCORE_W-1:0] score;
  } entry_t;

  // classified request passed from front to back
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    entry_t ent;
  } work_t;

  typedef struct packed {
    logic [7:0] cell_width;
    logic [7:0] cell_height;
    logic [6:0] cells_across;
    logic [6:0] cells_down;
    logic [SCORE_W-1:0] min_score;
  } cfg_t;

endpackage

[hw/rtl/grid_bucketed_corner_selector_top.sv]
// top level of the grid-bucketed corner selector: config registers, front, queue, back
//
// channel   direction  handshake             payload
// in        request    in_valid / in_ready    in_item_t in_data
// out       result     out_valid / out_ready  out_item_t out_data
// cfg       write      cfg_we                 cfg_index, cfg_data
//
// a candidate or mark goes through the front in order: accept, 14 restoring
// division steps for column and row together, the cell index, then the queue push
// the back takes a mark on acceptance; a candidate and each scanned cell of a flush
// wait for the registered read of the cell table; a flush closes with the last result
// reset is synchronous, empties the queue, clears all valid and occupancy bits and
// restores the config defaults
// either side may stall; the queue lets the front keep dividing while a flush drains

`timescale 1ns / 1ps

module grid_bucketed_corner_selector_top import gbcs_pkg::*; #(
  parameter int MAX_CELLS = 64,
  parameter int MAX_LEVELS = 4,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_item_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_item_t out_data,
  input  logic cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int Q_W = $bits(work_t) + IDX_W;

  cfg_t cfg;

  logic f_valid, f_ready;
  work_t f_work;
  logic [IDX_W-1:0] f_idx;
  logic b_valid, b_ready;
  work_t b_work;
  logic [IDX_W-1:0] b_idx;
  logic [Q_W-1:0] q_in, q_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cell_width <= 8'd32;
      cfg.cell_height <= 8'd32;
      cfg.cells_across <= 7'd8;
      cfg.cells_down <= 7'd8;
      cfg.min_score <= 24'd3840;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CELL_WIDTH: cfg.cell_width <= cfg_data[7:0];
        REG_CELL_HEIGHT: cfg.cell_height <= cfg_data[7:0];
        REG_CELLS_ACROSS: cfg.cells_across <= cfg_data[6:0];
        REG_CELLS_DOWN: cfg.cells_down <= cfg_data[6:0];
        REG_MIN_SCORE: cfg.min_score <= cfg_data[SCORE_W-1:0];
        default: ;
      endcase
    end
  end

  gbcs_front #(
    .MAX_CELLS(MAX_CELLS),
    .MAX_LEVELS(MAX_LEVELS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .wk_valid(f_valid),
    .wk_ready(f_ready),
    .wk_data(f_work),
    .wk_idx(f_idx)
  );

  assign q_in = {f_idx, f_work};
  assign b_idx = q_out[Q_W-1 -: IDX_W];
  assign b_work = q_out[$bits(work_t)-1:0];

  gbcs_queue #(
    .DEPTH(QUEUE_DEPTH),
    .DATA_W(Q_W)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push_valid(f_valid),
    .push_ready(f_ready),
    .push_data(q_in),
    .pop_valid(b_valid),
    .pop_ready(b_ready),
    .pop_data(q_out)
  );

  gbcs_back #(
    .MAX_CELLS(MAX_CELLS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .wk_valid(b_valid),
    .wk_ready(b_ready),
    .wk_data(b_work),
    .wk_idx(b_idx),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

endmodule

[hw/rtl/gbcs_front.sv]
// front end: accepts requests, scales coordinates and finds the cell by iterative division
`timescale 1ns / 1ps

module gbcs_front import gbcs_pkg::*; #(
  parameter int MAX_CELLS = 64,
  parameter int MAX_LEVELS = 4,
  localparam int IDX_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1
) (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic in_valid,
  output logic in_ready,
  input  in_item_t in_data,
  output logic wk_valid,
  input  logic wk_ready,
  output work_t wk_data,
  output logic [IDX_W-1:0] wk_idx
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_DIV = 2'd1;
  localparam logic [1:0] F_IDX = 2'd2;
  localparam logic [1:0] F_PUSH = 2'd3;
  localparam logic [3:0] LVL_LIM = 4'(MAX_LEVELS);
  localparam logic [3:0] LAST_STEP = 4'(DIV_STEPS - 1);
  localparam logic [COORD_W-1:0] CELL_LIM = COORD_W'(MAX_CELLS);

  logic [1:0] state;
  logic [3:0] step;
  logic [COORD_W-1:0] qx, qy;
  logic [7:0] rx, ry;
  work_t wk;
  logic [IDX_W-1:0] idx;

  logic [7:0] dw, dh;
  logic [8:0] tx, ty;
  logic [7:0] rx_next, ry_next;
  logic bx, by;
  logic [COORD_W-1:0] sx, sy;
  logic [COORD_W-1:0] lin;
  logic in_grid;

  assign in_ready = (state == F_IDLE);
  assign wk_valid = (state == F_PUSH);
  assign wk_data = wk;
  assign wk_idx = idx;

  // zero cell size counts as one
  assign dw = (cfg.cell_width == 8'd0) ? 8'd1 : cfg.cell_width;
  assign dh = (cfg.cell_height == 8'd0) ? 8'd1 : cfg.cell_height;

  // one restoring division step for each axis
  always_comb begin
    tx = {rx, qx[COORD_W-1]};
    ty = {ry, qy[COORD_W-1]};
    bx = (tx >= {1'b0, dw});
    by = (ty >= {1'b0, dh});
    rx_next = bx ? 8'(tx - {1'b0, dw}) : tx[7:0];
    ry_next = by ? 8'(ty - {1'b0, dh}) : ty[7:0];
  end

  assign sx = COORD_W'({3'b000, in_data.corner_x} << in_data.level);
  assign sy = COORD_W'({3'b000, in_data.corner_y} << in_data.level);

  assign in_grid = (qx < {7'd0, cfg.cells_across}) && (qy < {7'd0, cfg.cells_down});
  assign lin = COORD_W'(COORD_W'(qy[6:0]) * COORD_W'(cfg.cells_across)) + {7'd0, qx[6:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (in_valid) begin
            wk.cmd <= in_data.cmd;
            wk.ent.lvl <= in_data.level;
            wk.ent.score <= in_data.corner_score;
            wk.ent.x <= sx;
            wk.ent.y <= sy;
            rx <= 8'd0;
            ry <= 8'd0;
            step <= 4'd0;
            idx <= '0;
            priority if (in_data.cmd == CMD_FLUSH) begin
              state <= F_PUSH;
            end else if (in_data.cmd == CMD_CAND) begin
              qx <= sx;
              qy <= sy;
              if ({2'b00, in_data.level} < LVL_LIM) begin
                state <= F_DIV;
              end
            end else if (in_data.cmd == CMD_MARK) begin
              qx <= {3'b000, in_data.corner_x};
              qy <= {3'b000, in_data.corner_y};
              state <= F_DIV;
            end else begin
              state <= F_IDLE;
            end
          end
        end
        F_DIV: begin
          qx <= {qx[COORD_W-2:0], bx};
          qy <= {qy[COORD_W-2:0], by};
          rx <= rx_next;
          ry <= ry_next;
          step <= step + 4'd1;
          if (step == LAST_STEP) begin
            state <= F_IDX;
          end
        end
        F_IDX: begin
          idx <= lin[IDX_W-1:0];
          state <= (in_grid && (lin < CELL_LIM)) ? F_PUSH : F_IDLE;
        end
        F_PUSH: begin
          if (wk_ready) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/gbcs_queue.sv]
// small first-in first-out queue between front and back
`timescale 1ns / 1ps

module gbcs_queue #(
  parameter int DEPTH = 4,
  parameter int DATA_W = 8,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  logic [DATA_W-1:0] push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output logic [DATA_W-1:0] pop_data
);

  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

  logic [DATA_W-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic do_push, do_pop;

  assign push_ready = (count != FULL);
  assign pop_valid = (count != '0);
  assign pop_data = slots[rd_ptr];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

[hw/rtl/gbcs_back.sv]
// back end: cell table update, occupancy marks and flush scan with output register
`timescale 1ns / 1ps

module gbcs_back import gbcs_pkg::*; #(
  parameter int MAX_CELLS = 64,
  localparam int IDX_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1,
  localparam int CNT_W = $clog2(MAX_CELLS + 1)
) (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic wk_valid,
  output logic wk_ready,
  input  work_t wk_data,
  input  logic [IDX_W-1:0] wk_idx,
  output logic out_valid,
  input  logic out_ready,
  output out_item_t out_data
);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_CWAIT = 3'd1;
  localparam logic [2:0] B_CCMP = 3'd2;
  localparam logic [2:0] B_FWAIT = 3'd3;
  localparam logic [2:0] B_FCHK = 3'd4;
  localparam logic [2:0] B_FFIN = 3'd5;
  localparam logic [CNT_W-1:0] CELL_CNT = CNT_W'(MAX_CELLS);

  entry_t mem [MAX_CELLS];
  entry_t rd_data;

  logic [2:0] state;
  logic [CNT_W-1:0] scan_cell;
  logic [CNT_W-1:0] cell_inc;
  logic [IDX_W-1:0] addr;
  entry_t cur;
  logic [MAX_CELLS-1:0] valid;
  logic [MAX_CELLS-1:0] occupied;
  entry_t pend;
  logic pend_valid;

  logic out_free;
  logic out_load;
  logic [COORD_W-1:0] grid_cells;
  logic [SCORE_W-1:0] held;
  logic take;
  logic qual;
  logic scan_done;
  logic mem_we;

  assign wk_ready = (state == B_IDLE);
  assign out_free = !out_valid || out_ready;
  assign addr = scan_cell[IDX_W-1:0];
  assign cell_inc = scan_cell + CNT_W'(1);
  assign grid_cells = COORD_W'(cfg.cells_across) * COORD_W'(cfg.cells_down);
  assign scan_done = ({{(COORD_W - CNT_W){1'b0}}, cell_inc} >= grid_cells)
                     || (cell_inc == CELL_CNT);

  // an empty cell holds the current threshold as its score
  assign held = valid[addr] ? rd_data.score : cfg.min_score;
  assign take = !occupied[addr] && (cur.score > held);
  assign qual = valid[addr] && (rd_data.score > cfg.min_score);
  assign mem_we = (state == B_CCMP) && take;
  assign out_load = ((state == B_FCHK) && qual && pend_valid && out_free)
                    || ((state == B_FFIN) && out_free);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= cur;
    end
    rd_data <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      valid <= '0;
      occupied <= '0;
      pend_valid <= 1'b0;
      out_valid <= 1'b0;
      scan_cell <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (wk_valid) begin
            cur <= wk_data.ent;
            priority if (wk_data.cmd == CMD_CAND) begin
              scan_cell <= CNT_W'(wk_idx);
              state <= B_CWAIT;
            end else if (wk_data.cmd == CMD_MARK) begin
              occupied[wk_idx] <= 1'b1;
            end else if (wk_data.cmd == CMD_FLUSH) begin
              scan_cell <= '0;
              pend_valid <= 1'b0;
              state <= (grid_cells == '0) ? B_FFIN : B_FWAIT;
            end else begin
              state <= B_IDLE;
            end
          end
        end
        B_CWAIT: state <= B_CCMP;
        B_CCMP: begin
          if (take) begin
            valid[addr] <= 1'b1;
          end
          state <= B_IDLE;
        end
        B_FWAIT: state <= B_FCHK;
        B_FCHK: begin
          // a held result goes out only once a later one proves it is not the last
          if (!(qual && pend_valid && !out_free)) begin
            if (qual) begin
              if (pend_valid) begin
                out_data <= '{found: 1'b1, feature_x: pend.x, feature_y: pend.y,
                              feature_level: pend.lvl, feature_score: pend.score,
                              last: 1'b0};
              end
              pend <= rd_data;
              pend_valid <= 1'b1;
            end
            if (scan_done) begin
              state <= B_FFIN;
            end else begin
              scan_cell <= cell_inc;
              state <= B_FWAIT;
            end
          end
        end
        B_FFIN: begin
          if (out_free) begin
            if (pend_valid) begin
              out_data <= '{found: 1'b1, feature_x: pend.x, feature_y: pend.y,
                            feature_level: pend.lvl, feature_score: pend.score,
                            last: 1'b1};
            end else begin
              out_data <= '{found: 1'b0, feature_x: '0, feature_y: '0,
                            feature_level: '0, feature_score: '0, last: 1'b1};
            end
            valid <= '0;
            occupied <= '0;
            pend_valid <= 1'b0;
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

[tb/sv/gbcs_result_checker.sv]
// result checker for the grid-bucketed corner selector: predicts flush output and compares it
`timescale 1ns / 1ps

module gbcs_result_checker import gbcs_pkg::*; #(
  parameter int MAX_CELLS = 64,
  parameter int MAX_LEVELS = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_ready,
  input  in_item_t in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  out_item_t out_data,
  input  logic cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int failures,
  output int outstanding,
  output int results_checked
);

  // mirrored register file
  logic [7:0] cell_w;
  logic [7:0] cell_h;
  logic [6:0] across;
  logic [6:0] down;
  logic [SCORE_W-1:0] threshold;

  // mirrored cell tables
  logic slot_valid [MAX_CELLS];
  logic slot_taken [MAX_CELLS];
  entry_t slot [MAX_CELLS];

  out_item_t feature_q[$];
  int mismatches = 0;
  int compared = 0;

  assign failures = mismatches;
  assign results_checked = compared;

  task automatic clear_cells();
    for (int i = 0; i < MAX_CELLS; i++) begin
      slot_valid[i] = 1'b0;
      slot_taken[i] = 1'b0;
      slot[i] = '0;
    end
  endtask

  // linear cell index of a full-resolution position, or -1 off the grid or past the table
  function automatic int cell_index(input int x, input int y);
    int w, h, col, row, idx;
    w = (cell_w == 8'd0) ? 1 : int'(cell_w);
    h = (cell_h == 8'd0) ? 1 : int'(cell_h);
    col = x / w;
    row = y / h;
    if (col >= int'(across) || row >= int'(down)) return -1;
    idx = row * int'(across) + col;
    if (idx >= MAX_CELLS) return -1;
    return idx;
  endfunction

  task automatic apply_request(input in_item_t req);
    int fx, fy, idx, total, final_cell;
    logic [SCORE_W-1:0] held;
    out_item_t res;
    case (req.cmd)
      CMD_CAND: begin
        if (int'(req.level) < MAX_LEVELS) begin
          fx = (int'(req.corner_x) << req.level) & 'h3FFF;
          fy = (int'(req.corner_y) << req.level) & 'h3FFF;
          idx = cell_index(fx, fy);
          if (idx >= 0 && !slot_taken[idx]) begin
            held = slot_valid[idx] ? slot[idx].score : threshold;
            if (req.corner_score > held) begin
              slot_valid[idx] = 1'b1;
              slot[idx].x = COORD_W'(fx);
              slot[idx].y = COORD_W'(fy);
              slot[idx].lvl = req.level;
              slot[idx].score = req.corner_score;
            end
          end
        end
      end
      CMD_MARK: begin
        idx = cell_index(int'(req.corner_x), int'(req.corner_y));
        if (idx >= 0) slot_taken[idx] = 1'b1;
      end
      CMD_FLUSH: begin
        total = int'(across) * int'(down);
        if (total > MAX_CELLS) total = MAX_CELLS;
        final_cell = -1;
        for (int i = 0; i < total; i++) begin
          if (slot_valid[i] && slot[i].score > threshold) final_cell = i;
        end
        if (final_cell < 0) begin
          res = '0;
          res.last = 1'b1;
          feature_q = {feature_q, res};
        end else begin
          for (int i = 0; i <= final_cell; i++) begin
            if (slot_valid[i] && slot[i].score > threshold) begin
              res.found = 1'b1;
              res.feature_x = slot[i].x;
              res.feature_y = slot[i].y;
              res.feature_level = slot[i].lvl;
              res.feature_score = slot[i].score;
              res.last = (i == final_cell);
              feature_q = {feature_q, res};
            end
          end
        end
        clear_cells();
      end
      default: begin
      end
    endcase
  endtask

  function automatic void check_field(input string name, input logic [SCORE_W-1:0] want,
                                      input logic [SCORE_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      cell_w = 8'd32;
      cell_h = 8'd32;
      across = 7'd8;
      down = 7'd8;
      threshold = 24'd3840;
      feature_q.delete();
      clear_cells();
    end else begin
      // results first, so a request and a result in one cycle never mix
      if (out_valid && out_ready) begin
        if (feature_q.size() == 0) begin
          $error("unexpected result: found %0d x %0d y %0d score %0d", out_data.found,
                 out_data.feature_x, out_data.feature_y, out_data.feature_score);
          mismatches++;
        end else begin
          want = feature_q.pop_front();
          check_field("found", want.found, out_data.found);
          check_field("feature_x", want.feature_x, out_data.feature_x);
          check_field("feature_y", want.feature_y, out_data.feature_y);
          check_field("feature_level", want.feature_level, out_data.feature_level);
          check_field("feature_score", want.feature_score, out_data.feature_score);
          check_field("last", want.last, out_data.last);
          compared++;
        end
      end
      if (in_valid && in_ready) apply_request(in_data);
      if (cfg_we) begin
        case (cfg_index)
          REG_CELL_WIDTH: cell_w = cfg_data[7:0];
          REG_CELL_HEIGHT: cell_h = cfg_data[7:0];
          REG_CELLS_ACROSS: across = cfg_data[6:0];
          REG_CELLS_DOWN: down = cfg_data[6:0];
          REG_MIN_SCORE: threshold = cfg_data[SCORE_W-1:0];
          default: begin
          end
        endcase
      end
    end
    outstanding <= feature_q.size();
  end

  final begin
    if (feature_q.size() != 0) $error("%0d results never arrived", feature_q.size());
  end

endmodule

[tb/sv/tb_grid_bucketed_corner_selector_top.sv]
// testbench top of the grid-bucketed corner selector: stimulus, back-pressure and verdict
`timescale 1ns / 1ps

module tb_grid_bucketed_corner_selector_top import gbcs_pkg::*;;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 200;
  localparam int HOLD_CYCLES = 600;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int failures;
  int outstanding;
  int results_checked;

  int send_idle;
  int recv_idle;
  bit long_hold;
  int idle_cycles;
  int n_cand, n_mark, n_flush, n_other, n_settings;

  // what the stimulus last wrote, used to aim requests at the grid
  int grid_cw, grid_ch, grid_ca, grid_cd;
  logic [SCORE_W-1:0] grid_ms;

  grid_bucketed_corner_selector_top u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  gbcs_result_checker u_checker (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .failures(failures),
    .outstanding(outstanding),
    .results_checked(results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("watchdog: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic in_item_t make_request(input logic [CMD_W-1:0] cmd, input int x,
                                            input int y, input int lvl, input int score);
    in_item_t req;
    req.cmd = cmd;
    req.corner_x = IN_COORD_W'(x);
    req.corner_y = IN_COORD_W'(y);
    req.level = LVL_W'(lvl);
    req.corner_score = SCORE_W'(score);
    return req;
  endfunction

  function automatic in_item_t random_request();
    in_item_t req;
    int sel, ext_x, ext_y, tx, ty, lvl;
    longint s;
    sel = $urandom_range(0, 99);
    lvl = $urandom_range(0, 3);
    ext_x = ((grid_cw == 0) ? 1 : grid_cw) * ((grid_ca == 0) ? 1 : grid_ca);
    ext_y = ((grid_ch == 0) ? 1 : grid_ch) * ((grid_cd == 0) ? 1 : grid_cd);
    if (ext_x > 16384) ext_x = 16384;
    if (ext_y > 16384) ext_y = 16384;
    tx = $urandom_range(0, ext_x - 1);
    ty = $urandom_range(0, ext_y - 1);
    case ($urandom_range(0, 3))
      0: s = longint'($urandom & 32'hFFFFFF);
      1, 2: s = longint'(grid_ms) + longint'($urandom_range(0, 2048)) - 1024;
      default: s = longint'(grid_ms) + longint'($urandom_range(1, 65536));
    endcase
    if (s < 0) s = 0;
    if (s > 'hFFFFFF) s = 'hFFFFFF;
    if (sel < 70) begin
      if ((tx >> lvl) > 2047 || (ty >> lvl) > 2047) lvl = 3;
      req = make_request(CMD_CAND, tx >> lvl, ty >> lvl, lvl, int'(s));
    end else if (sel < 82) begin
      req = make_request(CMD_MARK, tx, ty, lvl, int'(s));
    end else if (sel < 92) begin
      req = make_request(CMD_FLUSH, tx, ty, lvl, int'(s));
    end else begin
      req = make_request(CMD_FLUSH + 2'd1, tx, ty, lvl, int'(s));
    end
    // noise: coordinates anywhere in the field range
    if ($urandom_range(0, 99) < 20) begin
      req.corner_x = IN_COORD_W'($urandom);
      req.corner_y = IN_COORD_W'($urandom);
    end
    return req;
  endfunction

  task automatic push_request(input in_item_t req);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    case (req.cmd)
      CMD_CAND: n_cand++;
      CMD_MARK: n_mark++;
      CMD_FLUSH: n_flush++;
      default: n_other++;
    endcase
  endtask

  // wait until every predicted result is in and the back end has gone quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(value);
    @(posedge clk);
  endtask

  task automatic program_grid(input int cw, input int ch, input int ca, input int cd,
                              input int ms);
    write_reg(REG_CELL_WIDTH, cw);
    write_reg(REG_CELL_HEIGHT, ch);
    write_reg(REG_CELLS_ACROSS, ca);
    write_reg(REG_CELLS_DOWN, cd);
    write_reg(REG_MIN_SCORE, ms);
    cfg_we <= 1'b0;
    grid_cw = cw & 'hFF;
    grid_ch = ch & 'hFF;
    grid_ca = ca & 'h7F;
    grid_cd = cd & 'h7F;
    grid_ms = SCORE_W'(ms);
    n_settings++;
  endtask

  // one grid setting: random requests closed by a flush; hold starts a long output stall
  task automatic run_phase(input int cw, input int ch, input int ca, input int cd,
                           input int ms, input int count, input int s_idle, input int r_idle,
                           input bit hold);
    in_item_t req;
    program_grid(cw, ch, ca, cd, ms);
    send_idle = s_idle;
    recv_idle = r_idle;
    if (hold) long_hold = 1'b1;
    for (int i = 0; i < count; i++) begin
      req = random_request();
      // two early flushes: the second waits behind the stalled output and backs up the input
      if (hold && (i == 5 || i == 6)) req.cmd = CMD_FLUSH;
      push_request(req);
    end
    push_request(make_request(CMD_FLUSH, 0, 0, 0, 0));
    settle();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle = 25;
    recv_idle = 53;
    long_hold = 1'b0;
    n_cand = 0;
    n_mark = 0;
    n_flush = 0;
    n_other = 0;
    n_settings = 1;
    grid_cw = 32;
    grid_ch = 32;
    grid_ca = 8;
    grid_cd = 8;
    grid_ms = 24'd3840;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, on the reset grid of 8 by 8 cells of 32 pixels
    push_request(make_request(CMD_FLUSH, 0, 0, 0, 0));             // nothing held
    push_request(make_request(CMD_CAND, 0, 0, 0, 3840));           // equal to threshold
    push_request(make_request(CMD_CAND, 0, 0, 0, 3841));
    push_request(make_request(CMD_CAND, 2047, 2047, 3, 'hFFFFFF)); // scaled off the grid
    push_request(make_request(CMD_CAND, 31, 31, 3, 'hFFFFFF));     // last cell
    push_request(make_request(CMD_CAND, 16, 0, 1, 5000));
    push_request(make_request(CMD_CAND, 17, 3, 1, 4000));          // weaker, same cell
    push_request(make_request(CMD_CAND, 18, 1, 1, 5000));          // tie keeps the first
    push_request(make_request(CMD_MARK, 40, 0, 0, 0));             // held entry survives
    push_request(make_request(CMD_CAND, 16, 0, 1, 9000));          // cell now occupied
    push_request(make_request(CMD_MARK, 2047, 2047, 3, 'hFFFFFF)); // off the grid
    push_request(make_request(CMD_MARK, 64, 0, 2, 0));
    push_request(make_request(CMD_CAND, 70, 5, 0, 'hFFFFFF));
    push_request(make_request(CMD_FLUSH + 2'd1, 2047, 2047, 3, 'hFFFFFF)); // unused code
    push_request(make_request(CMD_CAND, 2047, 0, 0, 'hFFFFFF));    // column too large
    push_request(make_request(CMD_CAND, 8, 8, 2, 'h000F01));
    push_request(make_request(CMD_FLUSH, 0, 0, 0, 0));
    push_request(make_request(CMD_FLUSH, 0, 0, 0, 0));             // cleared by the last
    push_request(make_request(CMD_CAND, 3, 3, 0, 0));
    push_request(make_request(CMD_CAND, 0, 255, 0, 'h7FFFFF));
    push_request(make_request(CMD_FLUSH, 0, 0, 0, 0));
    settle();

    run_phase(16, 16, 8, 8, 3840, 9, 25, 53, 1'b0);
    run_phase(255, 255, 64, 64, 0, 9, 25, 53, 1'b0);
    run_phase(1, 1, 1, 1, 'hFFFFFF, 9, 53, 25, 1'b0);
    run_phase(0, 0, 7, 9, 100, 9, 53, 25, 1'b0);               // zero cell size
    run_phase(40, 24, 0, 5, 2000, 9, 0, 0, 1'b0);              // zero grid size
    run_phase(200, 3, 127, 127, 7777, 9, 0, 0, 1'b0);
    run_phase(8, 8, 8, 8, 3840, 20, 0, 0, 1'b1);

    $display("sent %0d candidates, %0d marks, %0d flushes, %0d unused codes over %0d grids",
             n_cand, n_mark, n_flush, n_other, n_settings);
    $display("%0d flush results compared, including a long output stall", results_checked);
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
